FILE: sv/tmeb_pkg.sv
// shared constants and types of the triangle mesh edge builder
package tmeb_pkg;

   localparam int VERT_W      = 12;
   localparam int EDGE_W      = 14;
   localparam int FACE_W      = 13;
   localparam int TOT_W       = 15;
   localparam int FTOT_W      = 14;
   localparam int CNT_W       = 5;
   localparam int VAL_W       = 4;
   localparam int MAX_VERTICES = 4096;
   localparam int MAX_EDGES   = 16384;
   localparam int MAX_FACES   = 8192;
   localparam int MAX_VALENCE = 16;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EDGE_FULL = 2'd1;
   localparam logic [1:0] ST_VERT_FULL = 2'd2;
   localparam logic [1:0] ST_FACE_LIM  = 2'd3;

   // edge table entry: second face seen, then the two endpoints
   typedef struct packed {
      logic              has_second;
      logic [VERT_W-1:0] end0;
      logic [VERT_W-1:0] end1;
   } edge_word_type;

endpackage

FILE: sv/triangle_mesh_edge_builder_unit.sv
// top level of the triangle mesh edge builder: tables, sequencer and result register
// sequence: face limit check, reads of the three vertex counts, then per corner a scan of
//   the first endpoint's edge list and, for a new edge, its entry and both list writes;
//   on an overflow the second-face marks are undone; then count write-back and result word
// throughput: one face at a time, set by the scan of the vertex edge list memory,
//   one list entry per cycle through a two-deep read pipeline, plus any stalled result word
// reset: synchronous, active high; a clearing pass then zeroes the vertex counts
//   and new_mesh runs the same clearing pass before its face is handled
module triangle_mesh_edge_builder_unit
   import tmeb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [VERT_W-1:0] req_vert_a,
   input  logic [VERT_W-1:0] req_vert_b,
   input  logic [VERT_W-1:0] req_vert_c,
   input  logic              req_new_mesh,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [FACE_W-1:0] rsp_face_number,
   output logic [EDGE_W-1:0] rsp_edge_ab,
   output logic [EDGE_W-1:0] rsp_edge_bc,
   output logic [EDGE_W-1:0] rsp_edge_ca,
   output logic [2:0]        rsp_created_mask,
   output logic [TOT_W-1:0]  rsp_open_edges,
   output logic              rsp_mesh_closed,
   output logic [1:0]        rsp_status
);

   // sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_RD0    = 4'd3;
   localparam logic [3:0] S_RD1    = 4'd4;
   localparam logic [3:0] S_RD2    = 4'd5;
   localparam logic [3:0] S_RD3    = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_DECIDE = 4'd8;
   localparam logic [3:0] S_NEW1   = 4'd9;
   localparam logic [3:0] S_NEW2   = 4'd10;
   localparam logic [3:0] S_UNDO   = 4'd11;
   localparam logic [3:0] S_WB     = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   localparam int CLR_W = $clog2(MAX_VERTICES);

   // memories: edge table, vertex edge lists, vertex counts
   edge_word_type     edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0] list_mem [MAX_VERTICES*MAX_VALENCE];
   logic [CNT_W-1:0]  cnt_mem  [MAX_VERTICES];

   edge_word_type               edge_q;
   logic [EDGE_W-1:0]           list_q;
   logic [CNT_W-1:0]            cnt_q;
   logic                        edge_we;
   logic [EDGE_W-1:0]           edge_wa, edge_ra;
   edge_word_type               edge_wd;
   logic                        list_we;
   logic [VERT_W+VAL_W-1:0]     list_wa, list_ra;
   logic [EDGE_W-1:0]           list_wd;
   logic                        cnt_we;
   logic [VERT_W-1:0]           cnt_wa, cnt_ra;
   logic [CNT_W-1:0]            cnt_wd;

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_q <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      list_q <= list_mem[list_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_q <= cnt_mem[cnt_ra];
   end

   // control and working registers
   logic [3:0]        state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic              job_ff, job_in;
   logic [VERT_W-1:0] v_ff [3];
   logic [VERT_W-1:0] v_in [3];
   logic [FTOT_W-1:0] face_total_ff, face_total_in;
   logic [TOT_W-1:0]  edge_total_ff, edge_total_in;
   logic [TOT_W-1:0]  open_ff, open_in;
   logic [TOT_W-1:0]  sav_edges_ff, sav_edges_in;
   logic [TOT_W-1:0]  sav_open_ff, sav_open_in;
   logic [CNT_W-1:0]  cnt_ff [3];
   logic [CNT_W-1:0]  cnt_in [3];
   logic [CNT_W-1:0]  sav_ff [3];
   logic [CNT_W-1:0]  sav_in [3];
   logic [1:0]        j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              p1_ff, p1_in;
   logic              p2_ff, p2_in;
   logic [EDGE_W-1:0] p2id_ff, p2id_in;
   logic              found_ff, found_in;
   logic [EDGE_W-1:0] mid_ff, mid_in;
   edge_word_type     mword_ff, mword_in;
   logic [1:0]        ln_ff, ln_in;
   logic [EDGE_W-1:0] log_id_ff [3];
   logic [EDGE_W-1:0] log_id_in [3];
   edge_word_type     log_w_ff [3];
   edge_word_type     log_w_in [3];
   logic [EDGE_W-1:0] ids_ff [3];
   logic [EDGE_W-1:0] ids_in [3];
   logic [2:0]        mask_ff, mask_in;
   logic [1:0]        status_ff, status_in;
   logic [1:0]        wj_ff, wj_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [FACE_W-1:0] rsp_face_ff, rsp_face_in;
   logic [EDGE_W-1:0] rsp_ab_ff, rsp_ab_in;
   logic [EDGE_W-1:0] rsp_bc_ff, rsp_bc_in;
   logic [EDGE_W-1:0] rsp_ca_ff, rsp_ca_in;
   logic [2:0]        rsp_mask_ff, rsp_mask_in;
   logic [TOT_W-1:0]  rsp_open_ff, rsp_open_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // current corner edge (a, b)
   logic [1:0]        jn;
   logic [VERT_W-1:0] va, vb;
   logic              hit;
   logic              need_two;
   logic [CNT_W:0]    cnt_b_need;

   assign jn = (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
   assign va = v_ff[j_ff];
   assign vb = v_ff[jn];
   assign hit = (edge_q.end0 == va || edge_q.end0 == vb) &&
                (edge_q.end1 == va || edge_q.end1 == vb);
   assign need_two = (va == vb);
   assign cnt_b_need = {1'b0, cnt_ff[jn]} + (need_two ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      job_in        = job_ff;
      v_in          = v_ff;
      face_total_in = face_total_ff;
      edge_total_in = edge_total_ff;
      open_in       = open_ff;
      sav_edges_in  = sav_edges_ff;
      sav_open_in   = sav_open_ff;
      cnt_in        = cnt_ff;
      sav_in        = sav_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      p1_in         = 1'b0;
      p2_in         = 1'b0;
      p2id_in       = p2id_ff;
      found_in      = found_ff;
      mid_in        = mid_ff;
      mword_in      = mword_ff;
      ln_in         = ln_ff;
      log_id_in     = log_id_ff;
      log_w_in      = log_w_ff;
      ids_in        = ids_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      wj_in         = wj_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_face_in   = rsp_face_ff;
      rsp_ab_in     = rsp_ab_ff;
      rsp_bc_in     = rsp_bc_ff;
      rsp_ca_in     = rsp_ca_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_open_in   = rsp_open_ff;
      rsp_status_in = rsp_status_ff;

      edge_we = 1'b0;
      edge_wa = mid_ff;
      edge_wd = mword_ff;
      edge_ra = list_q;
      list_we = 1'b0;
      list_wa = {va, cnt_ff[j_ff][VAL_W-1:0]};
      list_wd = edge_total_ff[EDGE_W-1:0];
      list_ra = {va, k_ff[VAL_W-1:0]};
      cnt_we  = 1'b0;
      cnt_wa  = clr_ff;
      cnt_wd  = '0;
      cnt_ra  = v_ff[0];

      case (state_ff)
         S_CLEAR: begin
            // zero one vertex count a cycle
            cnt_we = 1'b1;
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(MAX_VERTICES - 1)) begin
               state_in = job_ff ? S_CHECK : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               v_in[0]   = req_vert_a;
               v_in[1]   = req_vert_b;
               v_in[2]   = req_vert_c;
               job_in    = 1'b1;
               clr_in    = '0;
               status_in = ST_OK;
               ln_in     = '0;
               mask_in   = '0;
               j_in      = '0;
               for (int i = 0; i < 3; i++) begin
                  ids_in[i] = '0;
               end
               if (req_new_mesh) begin
                  edge_total_in = '0;
                  face_total_in = '0;
                  open_in       = '0;
                  state_in      = S_CLEAR;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            sav_edges_in = edge_total_ff;
            sav_open_in  = open_ff;
            if (face_total_ff >= FTOT_W'(MAX_FACES)) begin
               status_in = ST_FACE_LIM;
               state_in  = S_FIN;
            end else begin
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            cnt_ra   = v_ff[0];
            state_in = S_RD1;
         end
         S_RD1: begin
            cnt_ra    = v_ff[1];
            cnt_in[0] = cnt_q;
            state_in  = S_RD2;
         end
         S_RD2: begin
            cnt_ra    = v_ff[2];
            cnt_in[1] = cnt_q;
            state_in  = S_RD3;
         end
         S_RD3: begin
            cnt_in[2] = cnt_q;
            sav_in[0] = cnt_ff[0];
            sav_in[1] = cnt_ff[1];
            sav_in[2] = cnt_q;
            k_in      = '0;
            found_in  = 1'b0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            // list read, then edge read, then compare; last match wins
            if (k_ff < cnt_ff[j_ff]) begin
               p1_in = 1'b1;
               k_in  = k_ff + CNT_W'(1);
            end
            if (p1_ff) begin
               p2_in   = 1'b1;
               p2id_in = list_q;
            end
            if (p2_ff && hit) begin
               found_in = 1'b1;
               mid_in   = p2id_ff;
               mword_in = edge_q;
            end
            if (k_ff == cnt_ff[j_ff] && !p1_ff && !p2_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (found_ff) begin
               log_id_in[ln_ff] = mid_ff;
               log_w_in[ln_ff]  = mword_ff;
               ln_in            = ln_ff + 2'd1;
               if (!mword_ff.has_second) begin
                  open_in = open_ff - TOT_W'(1);
               end
               edge_we            = 1'b1;
               edge_wa            = mid_ff;
               edge_wd            = mword_ff;
               edge_wd.has_second = 1'b1;
               ids_in[j_ff]       = mid_ff;
               if (j_ff == 2'd2) begin
                  wj_in    = '0;
                  state_in = S_WB;
               end else begin
                  j_in     = j_ff + 2'd1;
                  k_in     = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end else if (edge_total_ff >= TOT_W'(MAX_EDGES)) begin
               status_in = ST_EDGE_FULL;
               state_in  = S_UNDO;
            end else if (cnt_ff[j_ff] >= CNT_W'(MAX_VALENCE) ||
                         cnt_b_need > (CNT_W+1)'(MAX_VALENCE)) begin
               status_in = ST_VERT_FULL;
               state_in  = S_UNDO;
            end else begin
               state_in = S_NEW1;
            end
            if (state_in == S_UNDO) begin
               edge_total_in = sav_edges_ff;
               open_in       = sav_open_ff;
               mask_in       = '0;
               for (int i = 0; i < 3; i++) begin
                  ids_in[i] = '0;
               end
            end
         end
         S_NEW1: begin
            // new edge entry and its place in the first endpoint's list
            edge_we = 1'b1;
            edge_wa = edge_total_ff[EDGE_W-1:0];
            edge_wd = '{has_second: 1'b0, end0: va, end1: vb};
            list_we = 1'b1;
            list_wa = {va, cnt_ff[j_ff][VAL_W-1:0]};
            for (int i = 0; i < 3; i++) begin
               if (v_ff[i] == va) begin
                  cnt_in[i] = cnt_ff[i] + CNT_W'(1);
               end
            end
            state_in = S_NEW2;
         end
         S_NEW2: begin
            list_we = 1'b1;
            list_wa = {vb, cnt_ff[jn][VAL_W-1:0]};
            for (int i = 0; i < 3; i++) begin
               if (v_ff[i] == vb) begin
                  cnt_in[i] = cnt_ff[i] + CNT_W'(1);
               end
            end
            edge_total_in      = edge_total_ff + TOT_W'(1);
            open_in            = open_ff + TOT_W'(1);
            ids_in[j_ff]       = edge_total_ff[EDGE_W-1:0];
            mask_in[j_ff]      = 1'b1;
            if (j_ff == 2'd2) begin
               wj_in    = '0;
               state_in = S_WB;
            end else begin
               j_in     = j_ff + 2'd1;
               k_in     = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_UNDO: begin
            // put back second-face marks in reverse order
            if (ln_ff != 2'd0) begin
               edge_we = 1'b1;
               edge_wa = log_id_ff[ln_ff - 2'd1];
               edge_wd = log_w_ff[ln_ff - 2'd1];
               ln_in   = ln_ff - 2'd1;
            end else begin
               wj_in    = '0;
               state_in = S_WB;
            end
         end
         S_WB: begin
            cnt_we = 1'b1;
            cnt_wa = v_ff[wj_ff];
            cnt_wd = (status_ff == ST_OK) ? cnt_ff[wj_ff] : sav_ff[wj_ff];
            wj_in  = wj_ff + 2'd1;
            if (wj_ff == 2'd2) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_face_in   = (status_ff == ST_OK) ? face_total_ff[FACE_W-1:0] : '0;
               rsp_ab_in     = ids_ff[0];
               rsp_bc_in     = ids_ff[1];
               rsp_ca_in     = ids_ff[2];
               rsp_mask_in   = mask_ff;
               rsp_open_in   = open_ff;
               rsp_status_in = status_ff;
               if (status_ff == ST_OK) begin
                  face_total_in = face_total_ff + FTOT_W'(1);
               end
               job_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         job_ff        <= 1'b0;
         face_total_ff <= '0;
         edge_total_ff <= '0;
         open_ff       <= '0;
         p1_ff         <= 1'b0;
         p2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         job_ff        <= job_in;
         face_total_ff <= face_total_in;
         edge_total_ff <= edge_total_in;
         open_ff       <= open_in;
         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff          <= v_in;
      sav_edges_ff  <= sav_edges_in;
      sav_open_ff   <= sav_open_in;
      cnt_ff        <= cnt_in;
      sav_ff        <= sav_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      p2id_ff       <= p2id_in;
      found_ff      <= found_in;
      mid_ff        <= mid_in;
      mword_ff      <= mword_in;
      ln_ff         <= ln_in;
      log_id_ff     <= log_id_in;
      log_w_ff      <= log_w_in;
      ids_ff        <= ids_in;
      mask_ff       <= mask_in;
      status_ff     <= status_in;
      wj_ff         <= wj_in;
      rsp_face_ff   <= rsp_face_in;
      rsp_ab_ff     <= rsp_ab_in;
      rsp_bc_ff     <= rsp_bc_in;
      rsp_ca_ff     <= rsp_ca_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_face_number  = rsp_face_ff;
   assign rsp_edge_ab      = rsp_ab_ff;
   assign rsp_edge_bc      = rsp_bc_ff;
   assign rsp_edge_ca      = rsp_ca_ff;
   assign rsp_created_mask = rsp_mask_ff;
   assign rsp_open_edges   = rsp_open_ff;
   assign rsp_mesh_closed  = (rsp_open_ff == '0);
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTH
   // a skipped face never reports created edges
   a_skip_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_created_mask == 3'd0))
      else $error("skipped face reports created edges");

   // scan pipeline is empty whenever a new word can be taken
   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!p1_ff && !p2_ff))
      else $error("scan pipeline busy while idle");

   // face count never passes its limit
   a_face_bound: assert property (@(posedge clock) disable iff (reset)
      face_total_ff <= FTOT_W'(MAX_FACES))
      else $error("face count beyond limit");
`endif

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the triangle mesh edge builder
`timescale 1ns / 100ps

module tb_top;
   import tmeb_pkg::*;

   // ---------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // block ports
   // ---------------------------------------------------------------
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [VERT_W-1:0] req_vert_a = '0;
   logic [VERT_W-1:0] req_vert_b = '0;
   logic [VERT_W-1:0] req_vert_c = '0;
   logic              req_new_mesh = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [FACE_W-1:0] rsp_face_number;
   logic [EDGE_W-1:0] rsp_edge_ab;
   logic [EDGE_W-1:0] rsp_edge_bc;
   logic [EDGE_W-1:0] rsp_edge_ca;
   logic [2:0]        rsp_created_mask;
   logic [TOT_W-1:0]  rsp_open_edges;
   logic              rsp_mesh_closed;
   logic [1:0]        rsp_status;

   triangle_mesh_edge_builder_unit DUT (.*);

   // ---------------------------------------------------------------
   // expected result word
   // ---------------------------------------------------------------
   typedef struct packed {
      logic [FACE_W-1:0] face_number;
      logic [EDGE_W-1:0] edge_ab;
      logic [EDGE_W-1:0] edge_bc;
      logic [EDGE_W-1:0] edge_ca;
      logic [2:0]        created_mask;
      logic [TOT_W-1:0]  open_edges;
      logic              mesh_closed;
      logic [1:0]        status;
   } face_result_t;

   face_result_t face_results_pending[$];

   // ---------------------------------------------------------------
   // mirror of the mesh tables
   // ---------------------------------------------------------------
   logic [VERT_W-1:0] mir_end0 [MAX_EDGES];
   logic [VERT_W-1:0] mir_end1 [MAX_EDGES];
   logic [FACE_W-1:0] mir_first [MAX_EDGES];
   logic [FACE_W-1:0] mir_second [MAX_EDGES];
   logic              mir_paired [MAX_EDGES];
   logic [EDGE_W-1:0] mir_vlist [MAX_VERTICES*MAX_VALENCE];
   int unsigned       mir_vcount [MAX_VERTICES];
   int unsigned       mir_edge_total, mir_face_total, mir_open_total;

   function automatic void clear_mesh();
      foreach (mir_vcount[i]) mir_vcount[i] = 0;
      mir_edge_total = 0;
      mir_face_total = 0;
      mir_open_total = 0;
   endfunction

   // works out the result of one triangle and updates the mirror
   function automatic face_result_t build_face_edges(logic [VERT_W-1:0] va,
         logic [VERT_W-1:0] vb, logic [VERT_W-1:0] vc, logic nm);
      face_result_t r;
      int unsigned v[3], ids[3], cnt_save[3], log_id[3];
      logic log_paired[3];
      logic [FACE_W-1:0] log_second[3];
      int unsigned log_n, edges_save, open_save, a, b, n, need_b, id, face;
      logic [1:0] st;
      logic [2:0] mask;
      logic found;
      v[0] = 32'(va); v[1] = 32'(vb); v[2] = 32'(vc);
      ids = '{0, 0, 0};
      mask = '0;
      st = ST_OK;
      face = 0;
      log_n = 0;
      if (nm) clear_mesh();
      // indices are 12 bits wide, so no vertex can be out of range here
      if (mir_face_total >= MAX_FACES) st = ST_FACE_LIM;
      if (st == ST_OK) begin
         edges_save = mir_edge_total;
         open_save = mir_open_total;
         for (int j = 0; j < 3; j++) cnt_save[j] = mir_vcount[v[j]];
         face = mir_face_total;
         for (int j = 0; j < 3 && st == ST_OK; j++) begin
            a = v[j];
            b = v[(j+1)%3];
            n = mir_vcount[a];
            found = 1'b0;
            id = 0;
            // last matching entry wins
            for (int k = 0; k < n && k < MAX_VALENCE; k++) begin
               int unsigned e;
               e = 32'(mir_vlist[a*MAX_VALENCE+k]);
               if ((mir_end0[e] == a || mir_end0[e] == b) &&
                   (mir_end1[e] == a || mir_end1[e] == b)) begin
                  found = 1'b1;
                  id = e;
               end
            end
            if (found) begin
               log_id[log_n] = id;
               log_paired[log_n] = mir_paired[id];
               log_second[log_n] = mir_second[id];
               log_n++;
               if (!mir_paired[id]) mir_open_total--;
               mir_second[id] = FACE_W'(face);
               mir_paired[id] = 1'b1;
            end else begin
               need_b = (a == b) ? 2 : 1;
               if (mir_edge_total >= MAX_EDGES) st = ST_EDGE_FULL;
               else if (mir_vcount[a] >= MAX_VALENCE ||
                        mir_vcount[b] + need_b > MAX_VALENCE) st = ST_VERT_FULL;
               else begin
                  id = mir_edge_total++;
                  mir_end0[id] = VERT_W'(a);
                  mir_end1[id] = VERT_W'(b);
                  mir_first[id] = FACE_W'(face);
                  mir_second[id] = '0;
                  mir_paired[id] = 1'b0;
                  mir_vlist[a*MAX_VALENCE+mir_vcount[a]] = EDGE_W'(id);
                  mir_vcount[a]++;
                  mir_vlist[b*MAX_VALENCE+mir_vcount[b]] = EDGE_W'(id);
                  mir_vcount[b]++;
                  mir_open_total++;
                  mask[j] = 1'b1;
               end
            end
            if (st == ST_OK) ids[j] = id;
         end
         if (st != ST_OK) begin
            // roll back everything this face touched
            while (log_n > 0) begin
               log_n--;
               mir_paired[log_id[log_n]] = log_paired[log_n];
               mir_second[log_id[log_n]] = log_second[log_n];
            end
            for (int j = 2; j >= 0; j--) mir_vcount[v[j]] = cnt_save[j];
            mir_edge_total = edges_save;
            mir_open_total = open_save;
            ids = '{0, 0, 0};
            mask = '0;
            face = 0;
         end else mir_face_total++;
      end
      r.face_number = FACE_W'(face);
      r.edge_ab = EDGE_W'(ids[0]);
      r.edge_bc = EDGE_W'(ids[1]);
      r.edge_ca = EDGE_W'(ids[2]);
      r.created_mask = mask;
      r.open_edges = TOT_W'(mir_open_total);
      r.mesh_closed = (mir_open_total == 0);
      r.status = st;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // directed table: a typed-in result is compared only where fixed is set
   // ---------------------------------------------------------------
   typedef struct {
      logic [VERT_W-1:0] va, vb, vc;
      logic              nm;
      logic              fixed;
      face_result_t      want;
   } face_row_t;

   localparam int N_ROWS = 14;
   face_row_t face_rows [N_ROWS];
   initial begin
      // first face after reset: three new edges, three open
      face_rows[0]  = '{0, 1, 2, 0, 1, '{0, 0, 1, 2, 3'b111, 3, 0, ST_OK}};
      // opposite winding closes all three
      face_rows[1]  = '{2, 1, 0, 0, 1, '{1, 1, 0, 2, 3'b000, 0, 1, ST_OK}};
      // third face on the same edges overwrites the second face
      face_rows[2]  = '{0, 1, 2, 0, 0, '{default: '0}};
      // extreme indices
      face_rows[3]  = '{4095, 4095, 4094, 0, 0, '{default: '0}};
      face_rows[4]  = '{4095, 0, 2048, 0, 0, '{default: '0}};
      // fully degenerate triangle: an edge becomes its own second face
      face_rows[5]  = '{7, 7, 7, 0, 0, '{default: '0}};
      face_rows[6]  = '{7, 7, 7, 0, 0, '{default: '0}};
      // new_mesh clears, numbering restarts
      face_rows[7]  = '{100, 200, 300, 1, 1, '{0, 0, 1, 2, 3'b111, 3, 0, ST_OK}};
      face_rows[8]  = '{300, 200, 400, 0, 0, '{default: '0}};
      face_rows[9]  = '{2730, 1365, 0, 0, 0, '{default: '0}};
      face_rows[10] = '{1365, 2730, 4095, 0, 0, '{default: '0}};
      face_rows[11] = '{0, 0, 5, 0, 0, '{default: '0}};
      face_rows[12] = '{3, 3, 3, 1, 1, '{0, 0, 0, 0, 3'b001, 0, 1, ST_OK}};
      face_rows[13] = '{5, 6, 5, 0, 0, '{default: '0}};
   end

   // ---------------------------------------------------------------
   // stimulus generation
   // ---------------------------------------------------------------
   typedef struct {
      logic [VERT_W-1:0] va, vb, vc;
      logic nm;
   } tri_word_t;

   tri_word_t tri_words[$];
   face_result_t fixed_results[$];  // typed-in results, aligned with words
   logic         fixed_flags[$];

   // small vertex window so that edges are shared and lists fill up
   int unsigned win_base, win_span;

   function automatic logic [VERT_W-1:0] pick_vertex();
      return VERT_W'(win_base + $urandom_range(0, win_span - 1));
   endfunction

   int unsigned n_random, n_fan, n_overflow_words;

   task automatic plan_random();
      tri_word_t w;
      int unsigned mode;
      logic [VERT_W-1:0] hub;
      for (int i = 0; i < 750; i++) begin
         mode = $urandom_range(0, 19);
         w.nm = ($urandom_range(0, 79) == 0);
         if (w.nm || i == 0) begin
            win_base = $urandom_range(0, 4095 - 64);
            win_span = $urandom_range(4, 40);
         end
         if (mode == 0) begin
            // wide-open noise across the full index range
            w.va = VERT_W'($urandom);
            w.vb = VERT_W'($urandom);
            w.vc = VERT_W'($urandom);
         end else if (mode < 3) begin
            // fan round one hub to push its edge list to the limit
            hub = pick_vertex();
            w.va = hub; w.vb = pick_vertex(); w.vc = pick_vertex();
            n_fan++;
         end else if (mode == 3 && tri_words.size() > 0) begin
            // reverse an earlier face to pair its edges
            w = tri_words[$urandom_range(0, tri_words.size() - 1)];
            {w.va, w.vc} = {w.vc, w.va};
            w.nm = 1'b0;
         end else begin
            w.va = pick_vertex(); w.vb = pick_vertex(); w.vc = pick_vertex();
         end
         tri_words.push_back(w);
         fixed_flags.push_back(1'b0);
         fixed_results.push_back('{default: '0});
         n_random++;
      end
   endtask

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------
   int unsigned n_sent, n_checked, n_errors;
   logic        stimulus_done = 1'b0;
   int unsigned st_seen[4];

   initial begin
      tri_word_t w;
      int unsigned gap;
      foreach (face_rows[i]) begin
         w = '{face_rows[i].va, face_rows[i].vb, face_rows[i].vc, face_rows[i].nm};
         tri_words.push_back(w);
         fixed_flags.push_back(face_rows[i].fixed);
         fixed_results.push_back(face_rows[i].want);
      end
      plan_random();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (tri_words[i]) begin
         // first stretch runs with no idle cycles
         gap = (i < 40) ? 0 : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid    <= 1'b1;
         req_vert_a   <= tri_words[i].va;
         req_vert_b   <= tri_words[i].vb;
         req_vert_c   <= tri_words[i].vc;
         req_new_mesh <= tri_words[i].nm;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
      req_valid     <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // predict on acceptance
   always @(posedge clock) begin
      face_result_t r;
      if (!reset && req_valid && req_ready) begin
         r = build_face_edges(req_vert_a, req_vert_b, req_vert_c, req_new_mesh);
         if (fixed_flags[n_sent] && r != fixed_results[n_sent]) begin
            $error("predictor disagrees with table row %0d", n_sent);
            n_errors++;
         end
         face_results_pending.push_back(r);
         n_sent++;
      end
   end

   // ---------------------------------------------------------------
   // response side: random stalls, compare against oldest expectation
   // ---------------------------------------------------------------
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      face_result_t e;
      if (reset) rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready) begin
            if (face_results_pending.size() == 0) begin
               $error("unexpected result word");
               n_errors++;
            end else begin
               e = face_results_pending.pop_front();
               n_checked++;
               st_seen[rsp_status]++;
               if (rsp_face_number !== e.face_number) begin
                  $error("face_number exp %0d got %0d", e.face_number, rsp_face_number);
                  n_errors++;
               end
               if (rsp_edge_ab !== e.edge_ab) begin
                  $error("edge_ab exp %0d got %0d", e.edge_ab, rsp_edge_ab);
                  n_errors++;
               end
               if (rsp_edge_bc !== e.edge_bc) begin
                  $error("edge_bc exp %0d got %0d", e.edge_bc, rsp_edge_bc);
                  n_errors++;
               end
               if (rsp_edge_ca !== e.edge_ca) begin
                  $error("edge_ca exp %0d got %0d", e.edge_ca, rsp_edge_ca);
                  n_errors++;
               end
               if (rsp_created_mask !== e.created_mask) begin
                  $error("created_mask exp %0d got %0d", e.created_mask, rsp_created_mask);
                  n_errors++;
               end
               if (rsp_open_edges !== e.open_edges) begin
                  $error("open_edges exp %0d got %0d", e.open_edges, rsp_open_edges);
                  n_errors++;
               end
               if (rsp_mesh_closed !== e.mesh_closed) begin
                  $error("mesh_closed exp %0d got %0d", e.mesh_closed, rsp_mesh_closed);
                  n_errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status);
                  n_errors++;
               end
            end
         end
         // random stall after each word, none in the opening stretch
         if (rsp_ready && rsp_valid) begin
            stall_left = (n_checked < 40) ? 0 : $urandom_range(0, 3);
            rsp_ready <= (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
         end else rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // end of run
   // ---------------------------------------------------------------
   initial begin
      wait (stimulus_done);
      while (face_results_pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("faces sent %0d (%0d directed, %0d random, %0d hub fans), results checked %0d",
               n_sent, N_ROWS, n_random, n_fan, n_checked);
      $display("status seen: ok %0d, edge full %0d, list full %0d, face limit %0d",
               st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
      if (n_errors == 0 && face_results_pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // timeout covering the clearing pass of each new_mesh and the work of every face, with margin
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
